>>> rtl/spq_pkg.sv
// Package for the sorted insert priority queue: widths, command and status
// codes, and the control struct broadcast to every cell of the chain.
// No dependencies.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to all cells in the cycle a request is applied.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/sorted_insert_priority_queue_core.sv
// Top level of the sorted insert priority queue: a chain of spq_cell slots,
// the entry count and the result register. Depends on spq_pkg and spq_cell.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tuser: command; tdata: value
//  m_*       out        m_tvalid / m_tready  tuser: status;
//                                            tdata: removed_value, entry_count
//
// Cycles: one request per cycle while s_tready is high; each request is applied
// to the whole chain at once, since every cell compares the new value with its own
// entry and takes its data from itself or a neighbor. The result is registered
// and appears in the cycle after acceptance.
// Reset: synchronous; clears every cell's valid bit, the count and the output valid.
// Stalls: s_tready drops only while a result sits in the output register
// and the downstream side does not take it.
module sorted_insert_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] entry_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] w_data  [CAPACITY];
    logic                     w_valid [CAPACITY];
    logic                     w_shift [CAPACITY];

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    t_status                r_status;
    t_status                n_status;
    logic [DATA_W-1:0]      r_removed;
    logic [DATA_W-1:0]      n_removed;
    logic [COUNT_OUT_W-1:0] r_count_out;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    // The output register frees up in the same cycle it is taken.
    assign s_tready = !r_out_valid || m_tready;
    assign w_accept = s_tvalid && s_tready;

    // Fullness and emptiness come from the count, so freed front slots are
    // always usable: entries stay packed from slot zero.
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_ctl.ins   = w_accept && (s_tuser == CMD_INSERT) && !w_full;
    assign w_ctl.del   = w_accept && (s_tuser == CMD_DELETE) && !w_empty;
    assign w_ctl.value = signed'(s_tdata);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_prev_data;
            logic                     w_prev_valid;
            logic                     w_prev_shift;
            logic signed [DATA_W-1:0] w_next_data;
            logic                     w_next_valid;

            // Slot zero always becomes valid on an insert and has nothing
            // in front of it to shift in.
            if (gi == 0) begin : g_head
                assign w_prev_data  = '0;
                assign w_prev_valid = 1'b1;
                assign w_prev_shift = 1'b0;
            end else begin : g_body
                assign w_prev_data  = w_data[gi-1];
                assign w_prev_valid = w_valid[gi-1];
                assign w_prev_shift = w_shift[gi-1];
            end

            // The last slot empties on a delete.
            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next_data  = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_mid
                assign w_next_data  = w_data[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev_data  (w_prev_data),
                .i_prev_valid (w_prev_valid),
                .i_prev_shift (w_prev_shift),
                .i_next_data  (w_next_data),
                .i_next_valid (w_next_valid),
                .o_data       (w_data[gi]),
                .o_valid      (w_valid[gi]),
                .o_shift      (w_shift[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_status  = ST_DONE;
        n_removed = '0;
        if (s_tuser == CMD_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                n_removed = unsigned'(w_data[0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; entry_count shows the low bits of the count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_count_out <= COUNT_OUT_W'(n_count);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = {3'b000, r_count_out, r_removed};

endmodule

>>> rtl/spq_cell.sv
// One slot of the sorted chain: a stored entry and its valid bit.
// Depends on spq_pkg; instantiated by sorted_insert_priority_queue_core.
module spq_cell
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_prev_data,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_shift,
    input  logic signed [DATA_W-1:0] i_next_data,
    input  logic                     i_next_valid,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_valid,
    output logic                     o_shift
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_valid;
    logic                     n_valid;

    // The entry here moves back (or the slot is free) when the new value
    // does not exceed it, so a new value lands ahead of equal ones.
    assign o_shift = !r_valid || !(i_ctl.value > r_data);

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (i_prev_shift) begin
                n_data = i_prev_data;
            end else if (o_shift) begin
                n_data = i_ctl.value;
            end
            n_valid = r_valid | i_prev_valid;
        end else if (i_ctl.del) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

>>> rtl/spq_chk.sv
// Port-level checker for sorted_insert_priority_queue_core, bound to it below.
// Depends on spq_pkg.
module spq_chk
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A request that waits keeps its command and value.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    // A result is not dropped while downstream stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Requests are held off only by a pending, untaken result.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused without a stalled result");

    // A refused delete reports no value and an empty queue.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[31:0] == 32'd0)
            && (m_tdata[36:32] == 5'd0))
        else $error("empty status with value or count");

    // A refused insert reports a queue at capacity and no value.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[31:0] == 32'd0)
            && (m_tdata[36:32] == COUNT_OUT_W'(CAPACITY)))
        else $error("full status with wrong count or value");

endmodule

bind sorted_insert_priority_queue_core spq_chk #(.CAPACITY(CAPACITY)) u_spq_chk (.*);

>>> sim/sorted_insert_priority_queue_core_tb.sv
// Self-checking testbench for the sorted insert priority queue core.
// Depends on spq_pkg and the RTL of sorted_insert_priority_queue_core.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = CAPACITY_DEF;
    // Cycles with no request moving on either side before the run is abandoned.
    localparam int STALL_LIMIT    = 2000;
    localparam int LONG_HOLD      = 120;
    localparam int RANDOM_ITEMS   = 950;
    localparam int NO_IDLE_ITEMS  = 200;

    // One result as the queue should report it.
    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] removed_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } t_queue_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;     // [31:0] value
    logic               s_tuser;     // [0] command
    logic               m_tvalid;
    logic               m_tready;
    logic [39:0]        m_tdata;     // [31:0] removed_value, [36:32] entry_count
    logic [1:0]         m_tuser;     // [1:0] status

    // Shadow copy of the queue contents, kept in ascending order.
    logic signed [DATA_W-1:0] shadow_entries [QUEUE_DEPTH];
    int                       shadow_count;

    t_queue_result pending_results [$];

    int  error_count;
    int  idle_cycles;
    int  hold_request;
    bit  sender_gaps;
    bit  receiver_stalls;
    int  insert_count;
    int  delete_count;
    int  full_count;
    int  empty_count;

    sorted_insert_priority_queue_core #(
        .CAPACITY (QUEUE_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one request to the shadow queue and returns the result the
    // core should give for it. A new value is placed ahead of any equal
    // entries; a delete always takes slot zero.
    function automatic t_queue_result apply_queue_op(input logic cmd,
                                                     input logic signed [DATA_W-1:0] value);
        t_queue_result res;
        int            pos;
        res.status        = ST_DONE;
        res.removed_value = '0;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = shadow_count;
                while (pos > 0 && !(value > shadow_entries[pos-1])) begin
                    shadow_entries[pos] = shadow_entries[pos-1];
                    pos--;
                end
                shadow_entries[pos] = value;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_value = shadow_entries[0];
                for (int i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
            end
        end
        res.entry_count = shadow_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Offers one request and holds it until the core takes it. When sender
    // gaps are on, tvalid may drop for a burst of idle cycles afterwards.
    task automatic send_request(input logic cmd, input logic [31:0] value);
        t_queue_result res;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        res = apply_queue_op(cmd, value);
        pending_results.push_back(res);
        case (res.status)
            ST_FULL:  full_count++;
            ST_EMPTY: empty_count++;
            default: begin
                if (cmd == CMD_INSERT) insert_count++;
                else delete_count++;
            end
        endcase
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Values lean toward duplicates and the signed extremes so that ties
    // and wraparound in the ordering are exercised often.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 6)) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Sends items whose mix of inserts and deletes changes every few dozen
    // items, so the queue swings between full and empty many times.
    task automatic send_random_mix(input int n_items);
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 4))
                    0: insert_pct = 90;
                    1: insert_pct = 10;
                    2: insert_pct = 70;
                    3: insert_pct = 30;
                    default: insert_pct = 50;
                endcase
            end
            send_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE,
                         pick_value());
        end
    endtask

    // Empty delete, a fill with extremes and duplicates, a refused insert on
    // a full queue, and a few deletes with junk in the ignored value field.
    task automatic test_directed();
        logic [31:0] fill_values [16] = '{
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB,
            32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h0000_0000, 32'h0000_0064, 32'hFFFF_FF9C, 32'h0000_0005
        };
        send_request(CMD_DELETE, 32'hFFFF_FFFF);
        foreach (fill_values[i])
            send_request(CMD_INSERT, fill_values[i]);
        send_request(CMD_INSERT, 32'hDEAD_BEEF);
        send_request(CMD_DELETE, 32'h0000_0000);
        send_request(CMD_DELETE, 32'hFFFF_FFFF);
        send_request(CMD_DELETE, 32'h1234_5678);
        send_request(CMD_DELETE, 32'h8000_0000);
        send_request(CMD_DELETE, 32'h7FFF_FFFF);
        stop_sending();
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        send_random_mix(RANDOM_ITEMS);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and s_tready has to drop.
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        hold_request = LONG_HOLD;
        send_random_mix(40);
        sender_gaps = 1'b1;
    endtask

    // The sender goes quiet until every result is back, then resumes.
    task automatic test_pause_until_drained();
        send_random_mix(30);
        stop_sending();
        wait_for_drain();
        send_random_mix(30);
    endtask

    task automatic test_back_to_back();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_random_mix(NO_IDLE_ITEMS);
        stop_sending();
    endtask

    // Receiver side: random stall bursts, plus the long hold-off that a test
    // requests through hold_request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                hold_request--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker and progress counter for the watchdog. Values are taken
    // at the clock edge, before any of that edge's updates land.
    initial begin
        t_queue_result want;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (i_rst_n && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: status %0d, removed %0d, count %0d",
                           m_tuser, $signed(m_tdata[31:0]), m_tdata[36:32]);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[31:0] !== want.removed_value) begin
                        $error("removed_value mismatch: expected %0d, got %0d",
                               want.removed_value, $signed(m_tdata[31:0]));
                        error_count++;
                    end
                    if (m_tdata[36:32] !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, m_tdata[36:32]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    initial begin
        @(posedge i_clk);
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("** sorted_insert_priority_queue_core: FAILED **");
        $finish;
    end

    initial begin
        error_count     = 0;
        hold_request    = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        insert_count    = 0;
        delete_count    = 0;
        full_count      = 0;
        empty_count     = 0;
        shadow_count    = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_INSERT;
        s_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_pause_until_drained();
        test_back_to_back();

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d inserts and %0d deletes that went through,",
                 insert_count, delete_count);
        $display("%0d inserts refused as full and %0d deletes refused as empty",
                 full_count, empty_count);
        if (error_count == 0)
            $display("** sorted_insert_priority_queue_core: PASSED **");
        else
            $display("** sorted_insert_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
